FILE: design/media_type_signature_sniffer_unit_macros.svh
// Assertion macros for the media type sniffer.
// Used by media_type_signature_sniffer_unit.sv; depends on nothing.
`ifndef MEDIA_TYPE_SIGNATURE_SNIFFER_UNIT_MACROS_SVH
`define MEDIA_TYPE_SIGNATURE_SNIFFER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MTSS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mtss: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define MTSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mtss: next-cycle check failed");

`endif

FILE: design/mtss_pkg.sv
// Shared types, constants and lookup functions of the media type sniffer.
// Depends on nothing; used by the top level, mtss_fetch and mtss_div.
package mtss_pkg;

   localparam int BUF_BYTES = 2048;
   localparam int ADDR_W    = $clog2(BUF_BYTES);
   localparam int CNT_W     = ADDR_W + 1;
   localparam int HEAD_N    = 12;
   localparam int HEAD_IDX_W = 4;
   localparam int FETCH_N   = 4;
   localparam int FCNT_W    = 3;
   localparam int WEBM_LIMIT = 38;
   localparam int MP4_BRAND_START = 16;

   // frame size divider
   localparam int NUM_W     = 26;
   localparam int DEN_W     = 16;
   localparam int DCNT_W    = 5;
   localparam int RATE_W    = 19;

   // result codes
   localparam logic [3:0] MT_NONE = 4'd0;
   localparam logic [3:0] MT_AIFF = 4'd1;
   localparam logic [3:0] MT_MPEG = 4'd2;
   localparam logic [3:0] MT_OGG  = 4'd3;
   localparam logic [3:0] MT_MIDI = 4'd4;
   localparam logic [3:0] MT_AVI  = 4'd5;
   localparam logic [3:0] MT_WAVE = 4'd6;
   localparam logic [3:0] MT_MP4  = 4'd7;
   localparam logic [3:0] MT_WEBM = 4'd8;

   typedef logic [0:HEAD_N-1][7:0]  head_type;
   typedef logic [0:FETCH_N-1][7:0] win_type;

   typedef struct packed {
      logic             go;
      logic [CNT_W-1:0] base;
   } fetch_req_type;

   typedef struct packed {
      logic             go;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   // signature rows, first hit wins
   localparam int SIG_ROWS = 6;
   localparam head_type SIG_PAT [SIG_ROWS] = '{
      96'h464F524D_00000000_41494646,
      96'h494433_00_00000000_00000000,
      96'h4F676753_00_000000_00000000,
      96'h4D546864_00000006_00000000,
      96'h52494646_00000000_41564920,
      96'h52494646_00000000_57415645
   };
   localparam head_type SIG_MSK [SIG_ROWS] = '{
      96'hFFFFFFFF_00000000_FFFFFFFF,
      96'hFFFFFF00_00000000_00000000,
      96'hFFFFFFFF_FF000000_00000000,
      96'hFFFFFFFF_FFFFFFFF_00000000,
      96'hFFFFFFFF_00000000_FFFFFFFF,
      96'hFFFFFFFF_00000000_FFFFFFFF
   };
   localparam logic [3:0] SIG_LEN [SIG_ROWS] = '{
      4'd12, 4'd3, 4'd5, 4'd8, 4'd12, 4'd12
   };
   localparam logic [3:0] SIG_CODE [SIG_ROWS] = '{
      MT_AIFF, MT_MPEG, MT_OGG, MT_MIDI, MT_AVI, MT_WAVE
   };

   function automatic logic [3:0] sig_code(head_type h, logic [CNT_W-1:0] len);
      logic [3:0] code;
      code = MT_NONE;
      for (int r = SIG_ROWS - 1; r >= 0; r--) begin
         if (len >= CNT_W'(SIG_LEN[r]) && (h & SIG_MSK[r]) == SIG_PAT[r]) begin
            code = SIG_CODE[r];
         end
      end
      return code;
   endfunction

   // frame header check: sync, layer III, legal bitrate and sample rate
   function automatic logic mp3_hdr_ok(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
      return (b0 == 8'hff) && (b1[7:5] == 3'b111) && (b1[2:1] == 2'd1)
         && (b2[7:4] != 4'hf) && (b2[3:2] != 2'd3);
   endfunction

   function automatic logic [RATE_W-1:0] rate_lookup(logic v25, logic [3:0] idx);
      logic [RATE_W-1:0] r;
      if (v25) begin
         case (idx)
            4'd1:    r = 19'd8000;
            4'd2:    r = 19'd16000;
            4'd3:    r = 19'd24000;
            4'd4:    r = 19'd32000;
            4'd5:    r = 19'd40000;
            4'd6:    r = 19'd48000;
            4'd7:    r = 19'd56000;
            4'd8:    r = 19'd64000;
            4'd9:    r = 19'd80000;
            4'd10:   r = 19'd96000;
            4'd11:   r = 19'd112000;
            4'd12:   r = 19'd128000;
            4'd13:   r = 19'd144000;
            4'd14:   r = 19'd160000;
            default: r = 19'd0;
         endcase
      end else begin
         case (idx)
            4'd1:    r = 19'd32000;
            4'd2:    r = 19'd40000;
            4'd3:    r = 19'd48000;
            4'd4:    r = 19'd56000;
            4'd5:    r = 19'd64000;
            4'd6:    r = 19'd80000;
            4'd7:    r = 19'd96000;
            4'd8:    r = 19'd112000;
            4'd9:    r = 19'd128000;
            4'd10:   r = 19'd160000;
            4'd11:   r = 19'd192000;
            4'd12:   r = 19'd224000;
            4'd13:   r = 19'd256000;
            4'd14:   r = 19'd320000;
            default: r = 19'd0;
         endcase
      end
      return r;
   endfunction

   function automatic logic [DEN_W-1:0] freq_lookup(logic [1:0] idx);
      logic [DEN_W-1:0] f;
      case (idx)
         2'd1:    f = 16'd48000;
         2'd2:    f = 16'd32000;
         default: f = 16'd44100;
      endcase
      return f;
   endfunction

endpackage

FILE: design/media_type_signature_sniffer_unit.sv
// Top level of the audio/video media type sniffer: byte store and sequencer.
// Depends on mtss_pkg, mtss_ram, mtss_fetch, mtss_div and the macros header.
//
// Bytes load at one a cycle while busy is low; up to 2048 are kept, later
// ones dropped. The byte flagged last starts classification and raises busy.
// Checks run in order: signature table, MP4 brand scan by brand slot, WebM
// DocType search (per byte examined, a request for a four-byte window, then
// the loader, which reads the header RAM one byte a cycle), then the MP3
// header pair (the 26-step frame size division, then the second header's
// window load). A long zero run in a WebM header costs one window load per
// stored byte. The single result appears for exactly one cycle on
// rsp_strobe with busy already low; it cannot be held, so it must be taken
// on that cycle.
`include "media_type_signature_sniffer_unit_macros.svh"

module media_type_signature_sniffer_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_strobe,
   output logic [3:0] rsp_media_type,
   output logic [11:0] rsp_bytes_examined
);
   import mtss_pkg::*;

   localparam logic [3:0] S_LOAD     = 4'd0;
   localparam logic [3:0] S_SIG      = 4'd1;
   localparam logic [3:0] S_MP4      = 4'd2;
   localparam logic [3:0] S_MP4_LOOP = 4'd3;
   localparam logic [3:0] S_MP4_WAIT = 4'd4;
   localparam logic [3:0] S_WEBM     = 4'd5;
   localparam logic [3:0] S_W_LOOP   = 4'd6;
   localparam logic [3:0] S_W_ID     = 4'd7;
   localparam logic [3:0] S_W_ZERO   = 4'd8;
   localparam logic [3:0] S_W_ZWAIT  = 4'd9;
   localparam logic [3:0] S_W_TEST   = 4'd10;
   localparam logic [3:0] S_W_TWAIT  = 4'd11;
   localparam logic [3:0] S_MP3      = 4'd12;
   localparam logic [3:0] S_MP3_DIV  = 4'd13;
   localparam logic [3:0] S_MP3_WAIT = 4'd14;

   logic [3:0]        state_ff, state_in;
   logic [CNT_W-1:0]  kept_ff, kept_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  box_ff, box_in;
   logic              pad_ff, pad_in;
   head_type          head_ff;
   head_type          head_z;
   logic              strobe_ff, strobe_in;
   logic [3:0]        type_ff, type_in;
   logic [11:0]       bytes_ff, bytes_in;

   logic              accept;
   logic              wr_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   fetch_req_type     fetch_req;
   win_type           win;
   logic              fetch_done;
   div_req_type       div_req;
   logic [NUM_W-1:0]  quo;
   logic              div_done;

   // vint and frame size scratch
   logic [31:0]       box_word;
   logic [CNT_W-1:0]  p2, rest;
   logic [3:0]        lz, vsize;
   logic [NUM_W:0]    fsize;
   logic [1:0]        ver;
   logic [RATE_W-1:0] rate;
   logic [3:0]        sig;

   assign busy   = state_ff != S_LOAD;
   assign accept = start && !busy;
   assign wr_en  = accept && (kept_ff < CNT_W'(BUF_BYTES));

   mtss_ram #(.WIDTH(8), .DEPTH(BUF_BYTES)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (kept_ff[ADDR_W-1:0]),
      .wr_data (req_data_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mtss_fetch u_fetch (
      .clock   (clock),
      .reset   (reset),
      .req     (fetch_req),
      .len     (len_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .win     (win),
      .done    (fetch_done)
   );

   mtss_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .quo   (quo),
      .done  (div_done)
   );

   // zero the leading bytes that lie past the length
   always_comb begin
      for (int i = 0; i < HEAD_N; i++) begin
         head_z[i] = (CNT_W'(i) < len_ff) ? head_ff[i] : 8'h00;
      end
   end

   assign sig      = sig_code(head_z, len_ff);
   assign box_word = {head_z[0], head_z[1], head_z[2], head_z[3]};
   assign ver      = head_z[1][4:3];
   assign rate     = rate_lookup(ver[0], head_z[2][7:4]);
   assign p2       = pos_ff + CNT_W'(2);
   assign rest     = len_ff - p2;
   assign fsize    = {1'b0, quo} + (NUM_W + 1)'(pad_ff);

   // count leading zeros of the vint's first byte
   always_comb begin
      lz = 4'd8;
      for (int b = 0; b < 8; b++) begin
         if (win[2][b]) begin
            lz = 4'(7 - b);
         end
      end
      vsize = (lz == 4'd8) ? 4'd8 : lz + 4'd1;
      if (rest < CNT_W'(vsize)) begin
         vsize = rest[3:0];
      end
   end

   // classification sequencer
   always_comb begin
      state_in  = state_ff;
      kept_in   = kept_ff;
      len_in    = len_ff;
      pos_in    = pos_ff;
      box_in    = box_ff;
      pad_in    = pad_ff;
      strobe_in = 1'b0;
      type_in   = type_ff;
      bytes_in  = bytes_ff;
      fetch_req = '0;
      div_req   = '0;
      unique case (state_ff)
         S_LOAD: begin
            if (accept) begin
               if (wr_en) begin
                  kept_in = kept_ff + CNT_W'(1);
               end
               if (req_last_byte) begin
                  len_in   = wr_en ? kept_ff + CNT_W'(1) : kept_ff;
                  kept_in  = '0;
                  state_in = S_SIG;
               end
            end
         end
         S_SIG: begin
            if (sig != MT_NONE) begin
               type_in  = sig;
               state_in = S_LOAD;
               strobe_in = 1'b1;
            end else begin
               state_in = S_MP4;
            end
         end
         S_MP4: begin
            state_in = S_WEBM;
            box_in   = box_word[CNT_W-1:0];
            pos_in   = CNT_W'(MP4_BRAND_START);
            if (len_ff >= CNT_W'(HEAD_N) && {20'd0, len_ff} >= box_word
                  && box_word[1:0] == 2'd0
                  && head_z[4] == 8'h66 && head_z[5] == 8'h74
                  && head_z[6] == 8'h79 && head_z[7] == 8'h70) begin
               if (head_z[8] == 8'h6d && head_z[9] == 8'h70 && head_z[10] == 8'h34) begin
                  type_in   = MT_MP4;
                  state_in  = S_LOAD;
                  strobe_in = 1'b1;
               end else begin
                  state_in = S_MP4_LOOP;
               end
            end
         end
         S_MP4_LOOP: begin
            if (pos_ff < box_ff) begin
               fetch_req.go   = 1'b1;
               fetch_req.base = pos_ff;
               state_in       = S_MP4_WAIT;
            end else begin
               state_in = S_WEBM;
            end
         end
         S_MP4_WAIT: begin
            if (fetch_done) begin
               if (win[0] == 8'h6d && win[1] == 8'h70 && win[2] == 8'h34) begin
                  type_in   = MT_MP4;
                  state_in  = S_LOAD;
                  strobe_in = 1'b1;
               end else begin
                  pos_in   = pos_ff + CNT_W'(4);
                  state_in = S_MP4_LOOP;
               end
            end
         end
         S_WEBM: begin
            pos_in = CNT_W'(4);
            if (len_ff >= CNT_W'(4) && head_z[0] == 8'h1a && head_z[1] == 8'h45
                  && head_z[2] == 8'hdf && head_z[3] == 8'ha3) begin
               state_in = S_W_LOOP;
            end else begin
               state_in = S_MP3;
            end
         end
         S_W_LOOP: begin
            if (pos_ff < len_ff && pos_ff < CNT_W'(WEBM_LIMIT)) begin
               fetch_req.go   = 1'b1;
               fetch_req.base = pos_ff;
               state_in       = S_W_ID;
            end else begin
               state_in = S_MP3;
            end
         end
         S_W_ID: begin
            if (fetch_done) begin
               if (win[0] == 8'h42 && win[1] == 8'h82) begin
                  if (p2 >= len_ff) begin
                     state_in = S_MP3;
                  end else if (vsize > 4'd1 && CNT_W'(vsize) >= rest) begin
                     state_in = S_MP3;
                  end else begin
                     pos_in   = p2 + CNT_W'(vsize);
                     state_in = S_W_ZERO;
                  end
               end else begin
                  pos_in   = pos_ff + CNT_W'(1);
                  state_in = S_W_LOOP;
               end
            end
         end
         S_W_ZERO: begin
            if (pos_ff < len_ff) begin
               fetch_req.go   = 1'b1;
               fetch_req.base = pos_ff;
               state_in       = S_W_ZWAIT;
            end else begin
               state_in = S_W_TEST;
            end
         end
         S_W_ZWAIT: begin
            if (fetch_done) begin
               if (win[0] == 8'h00) begin
                  pos_in   = pos_ff + CNT_W'(1);
                  state_in = S_W_ZERO;
               end else begin
                  state_in = S_W_TEST;
               end
            end
         end
         S_W_TEST: begin
            if (pos_ff >= len_ff - CNT_W'(4)) begin
               state_in = S_MP3;
            end else begin
               fetch_req.go   = 1'b1;
               fetch_req.base = pos_ff;
               state_in       = S_W_TWAIT;
            end
         end
         S_W_TWAIT: begin
            if (fetch_done) begin
               if (win[0] == 8'h77 && win[1] == 8'h65 && win[2] == 8'h62 && win[3] == 8'h6d) begin
                  type_in   = MT_WEBM;
                  state_in  = S_LOAD;
                  strobe_in = 1'b1;
               end else begin
                  pos_in   = pos_ff + CNT_W'(1);
                  state_in = S_W_LOOP;
               end
            end
         end
         S_MP3: begin
            if (len_ff >= CNT_W'(4) && mp3_hdr_ok(head_z[0], head_z[1], head_z[2])) begin
               div_req.go  = 1'b1;
               div_req.num = (ver == 2'd1) ? NUM_W'(rate) * NUM_W'(72)
                                           : NUM_W'(rate) * NUM_W'(144);
               div_req.den = freq_lookup(head_z[2][3:2]);
               pad_in      = head_z[2][1];
               state_in    = S_MP3_DIV;
            end else begin
               type_in   = MT_NONE;
               state_in  = S_LOAD;
               strobe_in = 1'b1;
            end
         end
         S_MP3_DIV: begin
            if (div_done) begin
               if (fsize < (NUM_W + 1)'(4) || fsize > (NUM_W + 1)'(len_ff)
                     || (len_ff - fsize[CNT_W-1:0]) < CNT_W'(4)) begin
                  type_in   = MT_NONE;
                  state_in  = S_LOAD;
                  strobe_in = 1'b1;
               end else begin
                  fetch_req.go   = 1'b1;
                  fetch_req.base = fsize[CNT_W-1:0];
                  state_in       = S_MP3_WAIT;
               end
            end
         end
         S_MP3_WAIT: begin
            if (fetch_done) begin
               type_in   = mp3_hdr_ok(win[0], win[1], win[2]) ? MT_MPEG : MT_NONE;
               state_in  = S_LOAD;
               strobe_in = 1'b1;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
      if (strobe_in) begin
         bytes_in = len_ff[11:0];
      end
   end

   // hold state, capture the leading bytes as they load
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_LOAD;
         kept_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         kept_ff   <= kept_in;
         strobe_ff <= strobe_in;
      end
      if (accept && kept_ff < CNT_W'(HEAD_N)) begin
         head_ff[kept_ff[HEAD_IDX_W-1:0]] <= req_data_byte;
      end
      len_ff   <= len_in;
      pos_ff   <= pos_in;
      box_ff   <= box_in;
      pad_ff   <= pad_in;
      type_ff  <= type_in;
      bytes_ff <= bytes_in;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_media_type     = type_ff;
   assign rsp_bytes_examined = bytes_ff;

   `MTSS_ASSERT_SAME(a_idle_on_result, clock, reset, strobe_ff, !busy)
   `MTSS_ASSERT_NEXT(a_last_starts_scan, clock, reset, accept && req_last_byte, busy)
   `MTSS_ASSERT_SAME(a_code_range, clock, reset, strobe_ff, type_ff <= MT_WEBM)
   `MTSS_ASSERT_SAME(a_len_nonzero, clock, reset, strobe_ff, bytes_ff != 12'd0)
endmodule

FILE: design/mtss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module mtss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: design/mtss_fetch.sv
// Window loader: reads four consecutive stored bytes, zero past the length.
// Depends on mtss_pkg; drives the read port of the header RAM.
module mtss_fetch (
   input  logic                          clock,
   input  logic                          reset,
   input  mtss_pkg::fetch_req_type       req,
   input  logic [mtss_pkg::CNT_W-1:0]    len,
   output logic [mtss_pkg::ADDR_W-1:0]   rd_addr,
   input  logic [7:0]                    rd_data,
   output mtss_pkg::win_type             win,
   output logic                          done
);
   import mtss_pkg::*;

   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  addr_ff, addr_in;
   logic [FCNT_W-1:0] cnt_ff, cnt_in;
   logic              pend_ff, pend_in;
   logic              pend_ok_ff, pend_ok_in;
   win_type           win_ff, win_in;
   logic              done_ff, done_in;
   logic              issue;

   assign issue   = busy_ff && (cnt_ff != FCNT_W'(FETCH_N));
   assign rd_addr = addr_ff[ADDR_W-1:0];

   // issue one read a cycle, shift captured bytes into the window
   always_comb begin
      busy_in    = busy_ff;
      addr_in    = addr_ff;
      cnt_in     = cnt_ff;
      pend_in    = 1'b0;
      pend_ok_in = pend_ok_ff;
      win_in     = win_ff;
      done_in    = 1'b0;
      if (req.go) begin
         busy_in = 1'b1;
         addr_in = req.base;
         cnt_in  = '0;
      end else if (busy_ff) begin
         if (issue) begin
            pend_in    = 1'b1;
            pend_ok_in = addr_ff < len;
            addr_in    = addr_ff + CNT_W'(1);
            cnt_in     = cnt_ff + FCNT_W'(1);
         end
         if (pend_ff) begin
            win_in = {win_ff[1], win_ff[2], win_ff[3], pend_ok_ff ? rd_data : 8'h00};
            if (cnt_ff == FCNT_W'(FETCH_N)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pend_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         pend_ff <= pend_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      addr_ff    <= addr_in;
      pend_ok_ff <= pend_ok_in;
      win_ff     <= win_in;
   end

   assign win  = win_ff;
   assign done = done_ff;
endmodule

FILE: design/mtss_div.sv
// Restoring divider, one quotient bit per cycle, for the MP3 frame size.
// Depends on mtss_pkg.
module mtss_div (
   input  logic                          clock,
   input  logic                          reset,
   input  mtss_pkg::div_req_type         req,
   output logic [mtss_pkg::NUM_W-1:0]    quo,
   output logic                          done
);
   import mtss_pkg::*;

   logic              busy_ff, busy_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W:0]    rem_ff, rem_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic              done_ff, done_in;
   logic [DEN_W:0]    rem_sh;

   assign rem_sh = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};

   // shift in one dividend bit, subtract where it fits
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      done_in = 1'b0;
      if (req.go) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = req.num;
         den_in  = req.den;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + DCNT_W'(1);
         if (cnt_ff == DCNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign quo  = quo_ff;
   assign done = done_ff;
endmodule

FILE: tb/sv/media_type_signature_sniffer_unit_tb.sv
// Testbench for media_type_signature_sniffer_unit: a directed table of headers, then random headers, checked against
// typed media types or an in-bench media type classifier. Depends on mtss_pkg and the RTL.
`timescale 1ns / 100ps

module media_type_signature_sniffer_unit_tb;
   import mtss_pkg::*;

   localparam int WATCHDOG_LIMIT = 200000;
   localparam int TOTAL_BEATS    = 950;
   localparam int MAX_SHOWN      = 10;
   localparam int MAX_FRAME      = 400;

   typedef struct {
      logic [3:0]  media;
      logic [11:0] examined;
   } verdict_type;

   typedef struct {
      int         n;
      int         want;      // typed media type, or -1 to use the classifier
      logic [7:0] b [16];
   } header_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_last_byte = 1'b0;
   logic        rsp_strobe;
   logic [3:0]  rsp_media_type;
   logic [11:0] rsp_bytes_examined;

   media_type_signature_sniffer_unit uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data_byte(req_data_byte), .req_last_byte(req_last_byte),
      .rsp_strobe(rsp_strobe), .rsp_media_type(rsp_media_type),
      .rsp_bytes_examined(rsp_bytes_examined)
   );

   always #1 clock = ~clock;

   // classifier state: header bytes of the current resource
   logic [7:0]  hdr_mem [BUF_BYTES];
   int unsigned kept_len = 0;
   verdict_type pending_verdicts [$];
   logic [7:0]  seq_q [$];

   int error_count = 0;
   int beat_count = 0;
   int header_count = 0;
   int verdict_count = 0;
   int idle_pct = 0;
   int idle_cnt = 0;

   function automatic int unsigned hb(int unsigned i);
      return (i < kept_len) ? hdr_mem[i] : 0;
   endfunction

   function automatic logic [3:0] match_signature(int unsigned len);
      logic ok;
      for (int r = 0; r < SIG_ROWS; r++) begin
         if (len >= SIG_LEN[r]) begin
            ok = 1'b1;
            for (int i = 0; i < SIG_LEN[r]; i++) begin
               if (SIG_PAT[r][i] != (SIG_MSK[r][i] & hb(i))) ok = 1'b0;
            end
            if (ok) return SIG_CODE[r];
         end
      end
      return MT_NONE;
   endfunction

   function automatic logic mp4_brand(int unsigned len);
      int unsigned box;
      if (len < 12) return 1'b0;
      box = (hb(0) << 24) | (hb(1) << 16) | (hb(2) << 8) | hb(3);
      if (len < box || box[1:0] != 2'b00) return 1'b0;
      if (hb(4) != 8'h66 || hb(5) != 8'h74 || hb(6) != 8'h79 || hb(7) != 8'h70) return 1'b0;
      if (hb(8) == 8'h6d && hb(9) == 8'h70 && hb(10) == 8'h34) return 1'b1;
      for (int unsigned p = 16; p < box; p += 4) begin
         if (hb(p) == 8'h6d && hb(p + 1) == 8'h70 && hb(p + 2) == 8'h34) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic webm_doctype(int unsigned len);
      int unsigned p, rest, sz, bitv, first;
      p = 4;
      if (len < 4) return 1'b0;
      if (hb(0) != 8'h1a || hb(1) != 8'h45 || hb(2) != 8'hdf || hb(3) != 8'ha3) return 1'b0;
      while (p < len && p < WEBM_LIMIT) begin
         if (hb(p) == 8'h42 && hb(p + 1) == 8'h82) begin
            p += 2;
            if (p >= len) return 1'b0;
            rest = len - p;
            first = hb(p);
            sz = 1;
            bitv = 128;
            while (sz < 8 && sz < rest && (first & bitv) == 0) begin
               bitv >>= 1;
               sz++;
            end
            if (sz > 1 && sz >= rest) return 1'b0;
            p += sz;
            while (p < len && hb(p) == 0) p++;
            if (p >= len - 4) return 1'b0;
            if (hb(p) == 8'h77 && hb(p + 1) == 8'h65 && hb(p + 2) == 8'h62 && hb(p + 3) == 8'h6d)
               return 1'b1;
         end
         p++;
      end
      return 1'b0;
   endfunction

   function automatic logic frame_header_at(int unsigned s, int unsigned len);
      logic [7:0] b1, b2;
      if (s > len || len - s < 4) return 1'b0;
      b1 = hb(s + 1);
      b2 = hb(s + 2);
      if (hb(s) != 8'hff || (b1 & 8'he0) != 8'he0) return 1'b0;
      if (b1[2:1] == 2'd0 || b2[7:4] == 4'hf || b2[3:2] == 2'd3) return 1'b0;
      return b1[2:1] == 2'd1;
   endfunction

   // frame length in bytes that the header at the start implies
   function automatic int unsigned frame_bytes(logic [7:0] b1, logic [7:0] b2);
      int unsigned v1_kbps [15] = '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224,
                                    256, 320};
      int unsigned v25_kbps [15] = '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128,
                                     144, 160};
      int unsigned hz [3] = '{44100, 48000, 32000};
      int unsigned ver, rate, sz;
      ver = b1[4:3];
      if (b2[7:4] == 4'hf) return 0;
      rate = 1000 * (ver[0] ? v25_kbps[b2[7:4]] : v1_kbps[b2[7:4]]);
      sz = rate * (ver == 1 ? 72 : 144) / hz[b2[3:2] % 3];
      if (b2[1]) sz++;
      return sz;
   endfunction

   function automatic logic mpeg_pair(int unsigned len);
      int unsigned sz;
      if (!frame_header_at(0, len)) return 1'b0;
      sz = frame_bytes(hb(1), hb(2));
      if (sz < 4 || sz > len) return 1'b0;
      return frame_header_at(sz, len);
   endfunction

   function automatic logic [3:0] classify_header(int unsigned len);
      logic [3:0] code;
      code = match_signature(len);
      if (code != MT_NONE) return code;
      if (mp4_brand(len)) return MT_MP4;
      if (webm_doctype(len)) return MT_WEBM;
      if (mpeg_pair(len)) return MT_MPEG;
      return MT_NONE;
   endfunction

   // store an accepted beat; on the last one queue the verdict
   task automatic capture_byte(logic [7:0] b, logic last, int want);
      verdict_type v;
      if (kept_len < BUF_BYTES) begin
         hdr_mem[kept_len] = b;
         kept_len++;
      end
      if (last) begin
         v.media = (want >= 0) ? want[3:0] : classify_header(kept_len);
         v.examined = kept_len[11:0];
         pending_verdicts.push_back(v);
         kept_len = 0;
         header_count++;
      end
   endtask

   // drive one beat at the falling edge, hold until taken
   task automatic send_beat(logic [7:0] b, logic last, int want);
      @(negedge clock);
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      start <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (busy);
      beat_count++;
      capture_byte(b, last, want);
   endtask

   task automatic send_header(int want);
      for (int i = 0; i < seq_q.size(); i++) send_beat(seq_q[i], i == seq_q.size() - 1, want);
   endtask

   task automatic add_random(int n);
      repeat (n) seq_q.push_back(8'($urandom));
   endtask

   // build one random header, mostly well-formed with random content
   task automatic build_random_header();
      int kind, r, box, sz;
      logic [7:0] b1, b2;
      seq_q.delete();
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1: begin
            r = $urandom_range(0, SIG_ROWS - 1);
            for (int i = 0; i < SIG_LEN[r]; i++)
               seq_q.push_back(SIG_PAT[r][i] | (~SIG_MSK[r][i] & 8'($urandom)));
            add_random($urandom_range(0, 6));
            if ($urandom_range(0, 3) == 0) begin
               r = $urandom_range(0, seq_q.size() - 1);
               seq_q[r] = seq_q[r] ^ (8'd1 << $urandom_range(0, 7));
            end
         end
         2, 3: begin
            box = 4 * $urandom_range(3, 10) + ($urandom_range(0, 5) == 0 ? 1 : 0);
            seq_q.push_back(8'd0); seq_q.push_back(8'd0); seq_q.push_back(8'd0);
            seq_q.push_back(8'(box));
            seq_q.push_back(8'h66); seq_q.push_back(8'h74);
            seq_q.push_back(8'h79); seq_q.push_back(8'h70);
            add_random(box - 8);
            r = $urandom_range(0, 3);
            if (r == 0) begin
               seq_q[8] = 8'h6d; seq_q[9] = 8'h70; seq_q[10] = 8'h34;
            end else if (r != 3 && box >= 20) begin
               sz = 16 + 4 * $urandom_range(0, (box - 20) / 4);
               seq_q[sz] = 8'h6d; seq_q[sz + 1] = 8'h70; seq_q[sz + 2] = 8'h34;
            end
            add_random($urandom_range(0, 4));
            if ($urandom_range(0, 5) == 0) seq_q = seq_q[0:$urandom_range(8, seq_q.size() - 1)];
         end
         4, 5: begin
            seq_q = '{8'h1a, 8'h45, 8'hdf, 8'ha3};
            add_random($urandom_range(0, 34) % ($urandom_range(0, 1) ? 4 : 35));
            seq_q.push_back(8'h42); seq_q.push_back(8'h82);
            sz = $urandom_range(1, 8);
            seq_q.push_back(8'(8'h80 >> (sz - 1)) | ($urandom_range(0, 2) == 0 ? 8'($urandom) : 8'd0));
            add_random(sz - 1);
            repeat ($urandom_range(0, 5)) seq_q.push_back(8'd0);
            if ($urandom_range(0, 3) != 0) begin
               seq_q.push_back(8'h77); seq_q.push_back(8'h65);
               seq_q.push_back(8'h62); seq_q.push_back(8'h6d);
            end
            add_random($urandom_range(0, 5));
            if ($urandom_range(0, 4) == 0) seq_q = seq_q[0:$urandom_range(4, seq_q.size() - 1)];
         end
         6, 7: begin
            b1 = {3'b111, 2'($urandom), ($urandom_range(0, 5) == 0 ? 2'($urandom) : 2'd1),
                  1'($urandom)};
            b2 = {($urandom_range(0, 7) == 0 ? 4'($urandom) : 4'($urandom_range(1, 14))),
                  ($urandom_range(0, 7) == 0 ? 2'd3 : 2'($urandom_range(0, 2))), 2'($urandom)};
            seq_q = '{8'hff, b1, b2};
            sz = frame_bytes(b1, b2);
            // keep frames short so the beat budget covers many headers
            if (sz < 4 || sz > MAX_FRAME) sz = 8;
            add_random(sz - 3);
            seq_q.push_back(8'hff);
            seq_q.push_back($urandom_range(0, 4) == 0 ? 8'($urandom) : b1);
            seq_q.push_back(b2);
            add_random($urandom_range(1, 3));
            if ($urandom_range(0, 5) == 0) seq_q = seq_q[0:$urandom_range(2, seq_q.size() - 1)];
         end
         default: begin
            r = $urandom_range(1, 40);
            repeat (r) seq_q.push_back($urandom_range(0, 2) == 0 ? 8'hff : 8'($urandom));
         end
      endcase
   endtask

   // directed headers; bytes past 16 follow the index
   header_row_type directed [] = '{
      '{12, 1, '{8'h46, 8'h4F, 8'h52, 8'h4D, 8'h01, 8'h02, 8'h03, 8'h04,
                 8'h41, 8'h49, 8'h46, 8'h46, 0, 0, 0, 0}},
      '{3, 2, '{8'h49, 8'h44, 8'h33, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}},
      '{5, 3, '{8'h4F, 8'h67, 8'h67, 8'h53, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}},
      '{8, 4, '{8'h4D, 8'h54, 8'h68, 8'h64, 0, 0, 0, 8'h06, 0, 0, 0, 0, 0, 0, 0, 0}},
      '{12, 5, '{8'h52, 8'h49, 8'h46, 8'h46, 8'hff, 0, 0, 8'h80,
                 8'h41, 8'h56, 8'h49, 8'h20, 0, 0, 0, 0}},
      '{12, 6, '{8'h52, 8'h49, 8'h46, 8'h46, 0, 0, 0, 0,
                 8'h57, 8'h41, 8'h56, 8'h45, 0, 0, 0, 0}},
      '{12, 7, '{0, 0, 0, 8'h0C, 8'h66, 8'h74, 8'h79, 8'h70,
                 8'h6D, 8'h70, 8'h34, 8'h32, 0, 0, 0, 0}},
      '{13, -1, '{8'h1a, 8'h45, 8'hdf, 8'ha3, 8'h42, 8'h82, 8'h84, 8'h77,
                  8'h65, 8'h62, 8'h6d, 0, 0, 0, 0, 0}},
      '{2, -1, '{8'h49, 8'h44, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}},
      '{1, 0, '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}},
      '{4, -1, '{8'hff, 8'hfb, 8'h90, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}},
      '{16, -1, '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                  8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff}}
   };

   // check each result beat against the oldest verdict
   always @(posedge clock) begin
      verdict_type v;
      if (!reset && rsp_strobe) begin
         verdict_count <= verdict_count + 1;
         if (pending_verdicts.size() == 0) begin
            error_count++;
            if (error_count <= MAX_SHOWN)
               $display("unexpected result: media %0d examined %0d",
                        rsp_media_type, rsp_bytes_examined);
         end else begin
            v = pending_verdicts.pop_front();
            if (v.media !== rsp_media_type || v.examined !== rsp_bytes_examined) begin
               error_count++;
               if (error_count <= MAX_SHOWN)
                  $display("mismatch: expected media %0d examined %0d, got %0d %0d",
                           v.media, v.examined, rsp_media_type, rsp_bytes_examined);
            end
         end
      end
   end

   // watchdog: count cycles with no beat taken and no result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cnt <= 0;
      end else begin
         idle_cnt <= idle_cnt + 1;
         if (idle_cnt >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      int phase_beats;
      int phase_budget;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed[k]) begin
         seq_q.delete();
         for (int i = 0; i < directed[k].n; i++)
            seq_q.push_back(i < 16 ? directed[k].b[i] : 8'(i));
         send_header(directed[k].want);
      end

      // random headers in three idling phases, sharing the rest of the budget
      phase_budget = (TOTAL_BEATS - beat_count) / 3;
      for (int ph = 0; ph < 3; ph++) begin
         idle_pct = (ph == 0) ? 7 : (ph == 1) ? 51 : 0;
         phase_beats = beat_count + phase_budget;
         while (beat_count < phase_beats) begin
            build_random_header();
            send_header(-1);
         end
      end
      @(negedge clock);
      start <= 1'b0;

      // drain outstanding verdicts
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("covered %0d headers in %0d beats, %0d results checked",
               header_count, beat_count, verdict_count);
      if (error_count == 0 && pending_verdicts.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("%0d mismatches", error_count);
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
